// ===== hdl/wmpf_pkg.sv =====
// ---------------------------------------------------------------------------
// wmpf_pkg
// Shared types and constants of the multi-peak waveform finder.
// ---------------------------------------------------------------------------
package wmpf_pkg;

    localparam int MAX_PEAKS    = 20;
    localparam int MAX_SAMPLES  = 1024;
    localparam int PEAK_IDX_W   = $clog2(MAX_PEAKS);
    localparam int SAMPLE_CNT_W = $clog2(MAX_SAMPLES);

    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 16;
    localparam int PERIOD_W   = 8;
    localparam int GAIN_W     = 20;
    localparam int ENERGY_W   = SAMPLE_W + GAIN_W;
    localparam int CHARGE_W   = 22;
    localparam int LEVEL_W    = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = GAIN_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 88;

    localparam logic [LEVEL_W-1:0]  MIN_SENTINEL = '1;
    localparam logic [CHARGE_W-1:0] CHARGE_MAX   = '1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd5;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd65536;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_GAIN     = 1'b1;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } wmpf_sign_t;

    typedef enum logic {
        MODE_RUN,
        MODE_DRAIN
    } wmpf_mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   stamp;
        logic                last;
    } wmpf_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] amp;
        logic [TIME_W-1:0]   stamp;
    } wmpf_peak_t;

    typedef struct packed {
        logic [CHARGE_W-1:0]   charge;
        logic [PEAK_IDX_W-1:0] number;
        logic [TIME_W-1:0]     stamp;
        logic [ENERGY_W-1:0]   energy;
        logic [SAMPLE_W-1:0]   amp;
    } wmpf_result_t;

endpackage

// ===== hdl/wmpf_front.sv =====
// ---------------------------------------------------------------------------
// wmpf_front
// Accepts samples, counts the sample index, stamps each sample with its time
// and drops zero samples that do not close the waveform.
// ---------------------------------------------------------------------------
module wmpf_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [wmpf_pkg::SAMPLE_W-1:0]   sample,
    input  logic [wmpf_pkg::TIME_W-1:0]     start_time,
    input  logic                            last_sample,
    input  logic [wmpf_pkg::PERIOD_W-1:0]   period,
    output wmpf_pkg::wmpf_item_t            item,
    output logic                            item_valid,
    input  logic                            item_ready
);
    import wmpf_pkg::*;

    localparam int PROD_W = SAMPLE_CNT_W + PERIOD_W;
    localparam int SUM_W  = PROD_W + 5;

    logic [SAMPLE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                    valid_reg, valid_next;
    wmpf_item_t              item_reg;

    logic              accept;
    logic              keep;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic [TIME_W-1:0] stamp;

    assign s_ready    = !valid_reg || item_ready;
    assign accept     = s_valid && s_ready;
    assign keep       = (sample != '0) || last_sample;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    always_comb begin
        prod  = {{PERIOD_W{1'b0}}, cnt_reg} * {{SAMPLE_CNT_W{1'b0}}, period};
        sum   = {1'b0, prod, 4'b0000} + {{(SUM_W-TIME_W){1'b0}}, start_time};
        stamp = (|sum[SUM_W-1:TIME_W]) ? '1 : sum[TIME_W-1:0];

        cnt_next = cnt_reg;
        if (accept) begin
            if (last_sample) begin
                cnt_next = '0;
            end else if (cnt_reg != SAMPLE_CNT_W'(MAX_SAMPLES - 1)) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        valid_next = accept ? keep : (valid_reg && !item_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && keep) begin
            item_reg.sample <= sample;
            item_reg.stamp  <= stamp;
            item_reg.last   <= last_sample;
        end
    end

endmodule

// ===== hdl/wmpf_queue.sv =====
// ---------------------------------------------------------------------------
// wmpf_queue
// Short first-in first-out queue of stamped samples between front and back.
// ---------------------------------------------------------------------------
module wmpf_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wmpf_pkg::wmpf_item_t in_item,
    input  logic                 in_valid,
    output logic                 in_ready,
    output wmpf_pkg::wmpf_item_t out_item,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import wmpf_pkg::*;

    wmpf_item_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;

    logic push;
    logic pop;

    assign in_ready  = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/wmpf_back.sv =====
// ---------------------------------------------------------------------------
// wmpf_back
// Tracks peaks and minima by gradient sign, sums the charge, and on the last
// sample of a waveform reads out one request per peak.
// ---------------------------------------------------------------------------
module wmpf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wmpf_pkg::wmpf_item_t          item,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [wmpf_pkg::GAIN_W-1:0]   gain,
    output wmpf_pkg::wmpf_result_t        result,
    output logic                          result_last,
    output logic                          result_valid,
    input  logic                          result_ready
);
    import wmpf_pkg::*;

    wmpf_mode_t              mode_reg, mode_next;
    logic [LEVEL_W-1:0]      ref_reg, ref_next;
    wmpf_sign_t              sign_reg, sign_next;
    logic [LEVEL_W-1:0]      min_reg, min_next;
    logic [PEAK_IDX_W-1:0]   pk_idx_reg, pk_idx_next;
    logic [PEAK_IDX_W-1:0]   mn_idx_reg, mn_idx_next;
    logic [SAMPLE_W-1:0]     cur_amp_reg, cur_amp_next;
    logic [TIME_W-1:0]       cur_time_reg, cur_time_next;
    logic [CHARGE_W-1:0]     charge_reg, charge_next;
    logic [PEAK_IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                    r1_valid_reg, r1_valid_next;
    logic                    out_valid_reg, out_valid_next;

    wmpf_peak_t              peak_mem [MAX_PEAKS];
    wmpf_peak_t              rd_data_reg;
    logic                    r1_use_cur_reg;
    wmpf_peak_t              r1_cur_reg;
    logic [PEAK_IDX_W-1:0]   r1_number_reg;
    logic [CHARGE_W-1:0]     r1_charge_reg;
    wmpf_result_t            out_reg;
    logic                    out_last_reg;

    logic                    pop;
    logic                    wr_en;
    logic                    issue;
    logic                    r1_move;
    logic                    at_end;
    logic [LEVEL_W-1:0]      s_lvl;
    logic                    rise;
    logic                    fall;
    logic [CHARGE_W:0]       charge_sum;
    logic [SAMPLE_W-1:0]     amp_sel;
    wmpf_peak_t              sel_peak;

    assign item_ready   = mode_reg == MODE_RUN;
    assign pop          = item_valid && item_ready;
    assign r1_move      = r1_valid_reg && (!out_valid_reg || result_ready);
    assign issue        = (mode_reg == MODE_DRAIN) && (!r1_valid_reg || r1_move);
    assign at_end       = rd_idx_reg == pk_idx_reg;
    assign s_lvl        = {{(LEVEL_W-SAMPLE_W){1'b0}}, item.sample};
    assign rise         = s_lvl > ref_reg;
    assign fall         = s_lvl < ref_reg;
    assign charge_sum   = {1'b0, charge_reg} + {{(CHARGE_W+1-SAMPLE_W){1'b0}}, item.sample};
    assign result       = out_reg;
    assign result_last  = out_last_reg;
    assign result_valid = out_valid_reg;

    always_comb begin
        mode_next     = mode_reg;
        ref_next      = ref_reg;
        sign_next     = sign_reg;
        min_next      = min_reg;
        pk_idx_next   = pk_idx_reg;
        mn_idx_next   = mn_idx_reg;
        cur_amp_next  = cur_amp_reg;
        cur_time_next = cur_time_reg;
        charge_next   = charge_reg;
        rd_idx_next   = rd_idx_reg;
        wr_en         = 1'b0;

        if (pop && item.sample != '0) begin
            charge_next = charge_sum[CHARGE_W] ? CHARGE_MAX : charge_sum[CHARGE_W-1:0];
            if (rise) begin
                if (sign_reg == SIGN_POS) begin
                    if (item.sample > cur_amp_reg) begin
                        cur_amp_next  = item.sample;
                        cur_time_next = item.stamp;
                        ref_next      = s_lvl;
                    end else begin
                        ref_next = {{(LEVEL_W-SAMPLE_W){1'b0}}, cur_amp_reg};
                    end
                end else begin
                    ref_next = min_reg;
                    if (pk_idx_reg != PEAK_IDX_W'(MAX_PEAKS - 1)) begin
                        // close the current peak into the store, open a fresh one
                        wr_en         = 1'b1;
                        pk_idx_next   = pk_idx_reg + 1'b1;
                        cur_amp_next  = item.sample;
                        cur_time_next = item.stamp;
                    end else if (item.sample > cur_amp_reg) begin
                        cur_amp_next  = item.sample;
                        cur_time_next = item.stamp;
                    end
                end
                sign_next = SIGN_POS;
            end else begin
                if (fall && sign_reg == SIGN_NEG) begin
                    if (s_lvl < min_reg) begin
                        min_next = s_lvl;
                    end
                    ref_next = (s_lvl < min_reg) ? s_lvl : min_reg;
                end else begin
                    ref_next = {{(LEVEL_W-SAMPLE_W){1'b0}}, cur_amp_reg};
                    if (mn_idx_reg != PEAK_IDX_W'(MAX_PEAKS - 1)) begin
                        mn_idx_next = mn_idx_reg + 1'b1;
                        min_next    = s_lvl;
                    end else if (s_lvl < min_reg) begin
                        min_next = s_lvl;
                    end
                end
                sign_next = fall ? SIGN_NEG : SIGN_ZERO;
            end
        end

        if (pop && item.last) begin
            mode_next = MODE_DRAIN;
        end

        if (issue) begin
            if (at_end) begin
                // final request issued: clear the tracker for the next waveform
                mode_next     = MODE_RUN;
                rd_idx_next   = '0;
                ref_next      = '0;
                sign_next     = SIGN_POS;
                min_next      = MIN_SENTINEL;
                pk_idx_next   = '0;
                mn_idx_next   = '0;
                cur_amp_next  = '0;
                cur_time_next = '0;
                charge_next   = '0;
            end else begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
        end

        r1_valid_next  = issue ? 1'b1 : (r1_valid_reg && !r1_move);
        out_valid_next = r1_move ? 1'b1 : (out_valid_reg && !result_ready);

        sel_peak = r1_use_cur_reg ? r1_cur_reg : rd_data_reg;
        amp_sel  = sel_peak.amp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_RUN;
            ref_reg       <= '0;
            sign_reg      <= SIGN_POS;
            min_reg       <= MIN_SENTINEL;
            pk_idx_reg    <= '0;
            mn_idx_reg    <= '0;
            cur_amp_reg   <= '0;
            cur_time_reg  <= '0;
            charge_reg    <= '0;
            rd_idx_reg    <= '0;
            r1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            ref_reg       <= ref_next;
            sign_reg      <= sign_next;
            min_reg       <= min_next;
            pk_idx_reg    <= pk_idx_next;
            mn_idx_reg    <= mn_idx_next;
            cur_amp_reg   <= cur_amp_next;
            cur_time_reg  <= cur_time_next;
            charge_reg    <= charge_next;
            rd_idx_reg    <= rd_idx_next;
            r1_valid_reg  <= r1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            peak_mem[pk_idx_reg] <= {cur_amp_reg, cur_time_reg};
        end
        if (issue) begin
            rd_data_reg <= peak_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            r1_use_cur_reg <= at_end;
            r1_cur_reg     <= {cur_amp_reg, cur_time_reg};
            r1_number_reg  <= rd_idx_reg;
            r1_charge_reg  <= charge_reg;
        end
        if (r1_move) begin
            out_reg.amp    <= amp_sel;
            out_reg.energy <= {{GAIN_W{1'b0}}, amp_sel} * {{SAMPLE_W{1'b0}}, gain};
            out_reg.stamp  <= sel_peak.stamp;
            out_reg.number <= r1_number_reg;
            out_reg.charge <= r1_charge_reg;
            out_last_reg   <= r1_use_cur_reg;
        end
    end

endmodule

// ===== hdl/waveform_multi_peak_finder.sv =====
// ---------------------------------------------------------------------------
// waveform_multi_peak_finder
// Gradient sign change peak finder for calorimeter waveforms.
// ---------------------------------------------------------------------------
// Takes one sample per cycle unless the queue backs up. The front stage
// stamps each sample with its time (one small multiply and add) and feeds a
// four-entry queue; the back stage updates the peak tracker on each sample.
// On the last sample of a waveform with N peaks the back stage reads the N
// peaks out of the store, one result per cycle unless the result side
// stalls, through a two-stage read and energy-multiply pipeline, taking no new
// samples meanwhile; front stage and queue take up to five more kept ones.
// ---------------------------------------------------------------------------
module waveform_multi_peak_finder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [wmpf_pkg::S_TDATA_W-1:0]       s_tdata,  // sample, start_time
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // peak_amplitude, peak_energy, peak_time, peak_number, charge_sum
    output logic [wmpf_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wmpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wmpf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wmpf_pkg::*;

    localparam int RESULT_W = $bits(wmpf_result_t);

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;

    wmpf_item_t   front_item;
    logic         front_valid;
    logic         front_ready;
    wmpf_item_t   back_item;
    logic         back_valid;
    logic         back_ready;
    wmpf_result_t result;

    assign cfg_ready = 1'b1;

    always_comb begin
        period_next = period_reg;
        gain_next   = gain_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SAMPLE_PERIOD: period_next = cfg_data[PERIOD_W-1:0];
                CFG_PEAK_GAIN:     gain_next   = cfg_data[GAIN_W-1:0];
                default: begin
                    period_next = period_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            gain_reg   <= GAIN_RESET;
        end else begin
            period_reg <= period_next;
            gain_reg   <= gain_next;
        end
    end

    wmpf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .sample      (s_tdata[SAMPLE_W-1:0]),
        .start_time  (s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
        .last_sample (s_tlast),
        .period      (period_reg),
        .item        (front_item),
        .item_valid  (front_valid),
        .item_ready  (front_ready)
    );

    wmpf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (front_item),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_item  (back_item),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    wmpf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item         (back_item),
        .item_valid   (back_valid),
        .item_ready   (back_ready),
        .gain         (gain_reg),
        .result       (result),
        .result_last  (m_tlast),
        .result_valid (m_tvalid),
        .result_ready (m_tready)
    );

    assign m_tdata = {{(M_TDATA_W-RESULT_W){1'b0}}, result};

endmodule

// ===== tb/waveform_multi_peak_finder_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// waveform_multi_peak_finder_tb
// Self-checking bench for the multi-peak waveform finder.
// ---------------------------------------------------------------------------
// A short table of hand-picked samples comes first: empty and single-sample
// waveforms with their readout typed in, flat steps, rises after a flat
// step, time saturation and a zero last sample. Random waveforms follow in
// phases, each under its own sample period and gain: single pulses, pulse
// trains, saw teeth past the peak store's depth, noise and runts. A local
// peak tracker predicts the other readouts; results are checked field by field
// in order. Both sides idle at random, and once the result side holds off
// long enough for the finder to back up into its input.
// ---------------------------------------------------------------------------
module waveform_multi_peak_finder_tb;

    import wmpf_pkg::*;

    localparam int RANDOM_ITEMS   = 150;
    localparam int MIN_REPORTS    = 60;
    localparam int DRAIN_CYCLES   = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DIRECTED_ROWS  = 22;

    localparam int OFS_ENERGY = SAMPLE_W;
    localparam int OFS_TIME   = OFS_ENERGY + ENERGY_W;
    localparam int OFS_NUMBER = OFS_TIME + TIME_W;
    localparam int OFS_CHARGE = OFS_NUMBER + PEAK_IDX_W;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   amp;
        logic [ENERGY_W-1:0]   energy;
        logic [TIME_W-1:0]     stamp;
        logic [PEAK_IDX_W-1:0] number;
        logic [CHARGE_W-1:0]   charge;
        logic                  last;
    } peak_report_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   stamp;
        logic                last;
        logic                typed;
        peak_report_t        report;
    } stim_row_t;

    typedef enum {
        SHAPE_PULSE,
        SHAPE_TRAIN,
        SHAPE_SAW,
        SHAPE_NOISE,
        SHAPE_RUNT
    } shape_t;

    localparam peak_report_t NO_REPORT = '0;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // registers as last written
    logic [PERIOD_W-1:0] period_reg = PERIOD_RESET;
    logic [GAIN_W-1:0]   gain_reg   = GAIN_RESET;

    // peak tracker
    logic [LEVEL_W:0]        ref_level;
    wmpf_sign_t              slope_sign;
    logic [LEVEL_W-1:0]      valley_level;
    logic [PEAK_IDX_W-1:0]   peak_slot;
    logic [PEAK_IDX_W-1:0]   valley_slot;
    logic [SAMPLE_W-1:0]     peak_amp   [MAX_PEAKS];
    logic [TIME_W-1:0]       peak_stamp [MAX_PEAKS];
    logic [SAMPLE_CNT_W-1:0] sample_count;
    logic [CHARGE_W-1:0]     charge_acc;

    peak_report_t        peak_queue [$];
    peak_report_t        want;
    logic [SAMPLE_W-1:0] wave_buf [$];

    int mismatches   = 0;
    int reports_due  = 0;
    int random_items = 0;
    bit feed_calm    = 1'b0;
    bit drain_calm   = 1'b0;
    bit hold_request = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{12'd0,    16'h1234, 1'b1, 1'b1,
          '{12'd0, 32'd0, 16'd0, 5'd0, 22'd0, 1'b1}},
        '{12'd4095, 16'hFFFF, 1'b1, 1'b1,
          '{12'd4095, 32'h0FFF_0000, 16'hFFFF, 5'd0, 22'd4095, 1'b1}},
        '{12'd1,    16'h0000, 1'b1, 1'b1,
          '{12'd1, 32'd65536, 16'd0, 5'd0, 22'd1, 1'b1}},
        '{12'd100,  16'd100,  1'b0, 1'b0, NO_REPORT},
        '{12'd100,  16'd100,  1'b0, 1'b0, NO_REPORT},
        '{12'd0,    16'd100,  1'b0, 1'b0, NO_REPORT},
        '{12'd200,  16'd100,  1'b0, 1'b0, NO_REPORT},
        '{12'd150,  16'd100,  1'b0, 1'b0, NO_REPORT},
        '{12'd120,  16'd100,  1'b0, 1'b0, NO_REPORT},
        '{12'd4095, 16'd100,  1'b0, 1'b0, NO_REPORT},
        '{12'd4095, 16'd100,  1'b0, 1'b0, NO_REPORT},
        '{12'd1,    16'd100,  1'b0, 1'b0, NO_REPORT},
        '{12'd300,  16'd100,  1'b1, 1'b0, NO_REPORT},
        '{12'd2048, 16'hFFF0, 1'b0, 1'b0, NO_REPORT},
        '{12'd2049, 16'hFFF0, 1'b0, 1'b0, NO_REPORT},
        '{12'd1024, 16'hFFF0, 1'b0, 1'b0, NO_REPORT},
        '{12'd0,    16'hFFF0, 1'b1, 1'b0, NO_REPORT},
        '{12'h555,  16'hAAAA, 1'b0, 1'b0, NO_REPORT},
        '{12'hAAA,  16'hAAAA, 1'b0, 1'b0, NO_REPORT},
        '{12'h555,  16'hAAAA, 1'b0, 1'b0, NO_REPORT},
        '{12'hAAA,  16'hAAAA, 1'b1, 1'b0, NO_REPORT},
        '{12'h800,  16'h5555, 1'b1, 1'b0, NO_REPORT}
    };

    waveform_multi_peak_finder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_tracker();
        ref_level    = '0;
        slope_sign   = SIGN_POS;
        valley_level = MIN_SENTINEL;
        peak_slot    = '0;
        valley_slot  = '0;
        for (int i = 0; i < MAX_PEAKS; i++) begin
            peak_amp[i]   = '0;
            peak_stamp[i] = '0;
        end
        sample_count = '0;
        charge_acc   = '0;
    endfunction

    function automatic void note_peak(input logic [SAMPLE_W-1:0] smp,
                                      input logic [TIME_W-1:0] stamp);
        if (smp > peak_amp[peak_slot]) begin
            peak_amp[peak_slot]   = smp;
            peak_stamp[peak_slot] = stamp;
        end
    endfunction

    function automatic void track_sample(input logic [SAMPLE_W-1:0] smp,
                                         input logic [TIME_W-1:0] t0,
                                         input logic last, input bit publish);
        int                idx;
        int                full;
        int                sum;
        int                slope;
        logic [TIME_W-1:0] stamp;
        peak_report_t      r;
        idx = int'(sample_count);
        if (sample_count < MAX_SAMPLES - 1)
            sample_count++;
        if (smp != 0) begin
            sum = int'(charge_acc) + int'(smp);
            charge_acc = (sum > int'(CHARGE_MAX)) ? CHARGE_MAX : sum[CHARGE_W-1:0];
            full = int'(t0) + idx * int'(period_reg) * 16;
            stamp = (full > 65535) ? 16'hFFFF : full[TIME_W-1:0];
            slope = int'(smp) - int'(ref_level);
            if (slope > 0) begin
                if (slope_sign == SIGN_POS) begin
                    note_peak(smp, stamp);
                    ref_level = (LEVEL_W+1)'(peak_amp[peak_slot]);
                end else begin
                    ref_level = (LEVEL_W+1)'(valley_level);
                    if (peak_slot < MAX_PEAKS - 1)
                        peak_slot++;
                    note_peak(smp, stamp);
                end
                slope_sign = SIGN_POS;
            end else begin
                if (slope < 0 && slope_sign == SIGN_NEG) begin
                    if (smp < valley_level)
                        valley_level = LEVEL_W'(smp);
                    ref_level = (LEVEL_W+1)'(valley_level);
                end else begin
                    ref_level = (LEVEL_W+1)'(peak_amp[peak_slot]);
                    if (valley_slot < MAX_PEAKS - 1) begin
                        valley_slot++;
                        valley_level = MIN_SENTINEL;
                    end
                    if (smp < valley_level)
                        valley_level = LEVEL_W'(smp);
                end
                slope_sign = (slope < 0) ? SIGN_NEG : SIGN_ZERO;
            end
        end
        if (last) begin
            if (publish) begin
                for (int i = 0; i <= int'(peak_slot); i++) begin
                    r.amp    = peak_amp[i];
                    r.energy = ENERGY_W'(peak_amp[i]) * ENERGY_W'(gain_reg);
                    r.stamp  = peak_stamp[i];
                    r.number = PEAK_IDX_W'(i);
                    r.charge = charge_acc;
                    r.last   = (i == int'(peak_slot));
                    peak_queue = {peak_queue, r};
                    reports_due++;
                end
            end
            clear_tracker();
        end
    endfunction

    function automatic void check_field(input string label, input longint unsigned exp_v,
                                        input longint unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, label, exp_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic void add_pulse(input int len);
        int base;
        int top;
        int crest;
        int v;
        base  = ($urandom_range(3, 0) == 0) ? 0 : int'($urandom_range(300, 1));
        top   = $urandom_range(4095, base + 1);
        crest = $urandom_range(len - 2, 1);
        for (int i = 0; i < len; i++) begin
            if (i <= crest)
                v = base + (top - base) * i / crest;
            else
                v = base + (top - base) * (len - 1 - i) / (len - 1 - crest);
            if ($urandom_range(4, 0) == 0)
                v = v + int'($urandom_range(6, 0)) - 3;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            wave_buf = {wave_buf, v[SAMPLE_W-1:0]};
        end
    endfunction

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] t0,
                               input logic last, input bit publish);
        int gap;
        gap = feed_calm ? 0 : int'($urandom_range(8, 0));
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({t0, smp});
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_sample(smp, t0, last, publish);
    endtask

    task automatic play_waveform(input shape_t kind);
        logic [TIME_W-1:0] t0;
        int                v;
        wave_buf.delete();
        t0 = TIME_W'($urandom_range(65535, 0));
        case (kind)
            SHAPE_PULSE: add_pulse($urandom_range(16, 3));
            SHAPE_TRAIN: repeat ($urandom_range(5, 2)) add_pulse($urandom_range(8, 4));
            SHAPE_SAW: begin
                repeat ($urandom_range(24, 21)) begin
                    wave_buf = {wave_buf, 12'($urandom_range(4095, 2048))};
                    wave_buf = {wave_buf, 12'($urandom_range(1500, 1))};
                end
            end
            SHAPE_NOISE: begin
                repeat ($urandom_range(16, 3)) begin
                    v = $urandom_range(3, 0);
                    if (v == 0)
                        wave_buf = {wave_buf, 12'd0};
                    else if (v == 1 && wave_buf.size() != 0)
                        wave_buf = {wave_buf, wave_buf[$]};
                    else
                        wave_buf = {wave_buf, 12'($urandom_range(4095, 0))};
                end
            end
            default: begin
                repeat ($urandom_range(3, 1))
                    wave_buf = {wave_buf,
                                ($urandom_range(1, 0) ? 12'd0 : 12'($urandom_range(4095, 0)))};
            end
        endcase
        foreach (wave_buf[i])
            push_sample(wave_buf[i], t0, i == wave_buf.size() - 1, 1'b1);
        random_items += wave_buf.size();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (peak_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_registers(input logic [PERIOD_W-1:0] period,
                                     input logic [GAIN_W-1:0] gain);
        for (int i = 0; i < 2; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? CFG_SAMPLE_PERIOD : CFG_PEAK_GAIN;
            cfg_data  <= (i == 0) ? CFG_DATA_W'(period) : gain;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid  <= 1'b0;
        period_reg = period;
        gain_reg   = gain;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (peak_queue.size() == 0) begin
                $display("%0t ns: result expected none, got %h last %b", $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = peak_queue.pop_front();
                check_field("peak_amplitude", want.amp, m_tdata[OFS_ENERGY-1:0]);
                check_field("peak_energy", want.energy, m_tdata[OFS_ENERGY +: ENERGY_W]);
                check_field("peak_time", want.stamp, m_tdata[OFS_TIME +: TIME_W]);
                check_field("peak_number", want.number, m_tdata[OFS_NUMBER +: PEAK_IDX_W]);
                check_field("charge_sum", want.charge, m_tdata[OFS_CHARGE +: CHARGE_W]);
                check_field("last_peak", want.last, m_tlast);
            end
        end
    end

    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = drain_calm ? 0 : int'($urandom_range(8, 0));
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int     r;
        shape_t kind;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SAMPLE_PERIOD;
        cfg_data  <= '0;
        clear_tracker();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].typed) begin
                peak_queue = {peak_queue, directed_rows[i].report};
                reports_due++;
            end
            push_sample(directed_rows[i].sample, directed_rows[i].stamp,
                        directed_rows[i].last, !directed_rows[i].typed);
        end

        for (int phase = 0; random_items < RANDOM_ITEMS || reports_due < MIN_REPORTS;
             phase++) begin
            wait_drained();
            case (phase)
                0: program_registers(8'd0, 20'd0);
                1: program_registers(8'd255, 20'hFFFFF);
                2: program_registers(8'd1, 20'd1);
                default: program_registers(PERIOD_W'($urandom_range(255, 1)),
                                           GAIN_W'($urandom_range(20'hFFFFF, 0)));
            endcase
            feed_calm  = (phase % 4 == 0);
            drain_calm = (phase % 5 == 4);
            // hold the result side while samples keep coming
            if (phase == 0)
                hold_request = 1'b1;
            for (int w = 0; w < ((phase == 0) ? 6 : 3); w++) begin
                r = $urandom_range(9, 0);
                kind = (r < 4) ? SHAPE_PULSE : (r < 7) ? SHAPE_TRAIN : (r == 7) ? SHAPE_SAW :
                       (r == 8) ? SHAPE_NOISE : SHAPE_RUNT;
                if (phase == 1 && w == 0)
                    kind = SHAPE_SAW;
                play_waveform(kind);
            end
        end

        wait_drained();
        if (mismatches == 0 && peak_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/wmpf_pkg.sv
hdl/wmpf_front.sv
hdl/wmpf_queue.sv
hdl/wmpf_back.sv
hdl/waveform_multi_peak_finder.sv
tb/waveform_multi_peak_finder_tb.sv
